// ===== src/bvi_pkg.sv =====
package bvi_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [WordW-1:0] CrcPoly = 32'hEDB8_8320;
  localparam logic [WordW-1:0] CrcOnes = 32'hFFFF_FFFF;
  localparam logic [WordW-1:0] MinImage = 32'd8;
  localparam logic [WordW-1:0] MaxSizeReset = 32'd8;
  localparam logic [WordW-1:0] StackLowReset = 32'h2000_0000;
  localparam logic [WordW-1:0] StackHighReset = 32'h2002_0000;
  localparam logic [3:0] CaptureBytes = 4'd8;

  typedef enum logic [2:0] {
    StOk      = 3'd0,
    StMagic   = 3'd1,
    StVersion = 3'd2,
    StVector  = 3'd3,
    StSize    = 3'd4,
    StStack   = 3'd5,
    StReset   = 3'd6,
    StCrc     = 3'd7
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMagic     = 3'd0,
    CfgVersion   = 3'd1,
    CfgVectBase  = 3'd2,
    CfgMaxSize   = 3'd3,
    CfgStackLow  = 3'd4,
    CfgStackHigh = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [WordW-1:0] magic;
    logic [WordW-1:0] version;
    logic [WordW-1:0] vect_base;
    logic [WordW-1:0] max_size;
    logic [WordW-1:0] stack_low;
    logic [WordW-1:0] stack_high;
  } cfg_t;

  typedef struct packed {
    status_e          status;
    logic [WordW-1:0] crc;
  } res_t;

  function automatic logic [WordW-1:0] crc_byte(input logic [WordW-1:0] crc_in,
                                                input logic [ByteW-1:0] data);
    logic [WordW-1:0] crc;
    crc = crc_in ^ {{(WordW-ByteW){1'b0}}, data};
    for (int b = 0; b < ByteW; b++) begin
      crc = (crc >> 1) ^ (crc[0] ? CrcPoly : '0);
    end
    return crc;
  endfunction

endpackage

// ===== src/boot_image_validator.sv =====
// Checks a firmware image header against the configured magic, version, vector
// base and size limit, then runs the image bytes through a reflected CRC-32 and
// checks the initial stack pointer and reset vector taken from the first eight
// bytes. One transaction is taken per cycle, headers and data bytes alike; its
// result, if any, is registered in the output buffer. The CRC is updated a whole
// byte per cycle, and a two-entry output buffer lets the input keep flowing while
// one result waits; input stalls only while both entries are occupied.
// Configuration is written through a plain write port.
module boot_image_validator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [bvi_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [bvi_pkg::WordW-1:0]   cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        kind_i,
  input  logic [bvi_pkg::WordW-1:0]   magic_i,
  input  logic [bvi_pkg::WordW-1:0]   header_version_i,
  input  logic [bvi_pkg::WordW-1:0]   vector_base_i,
  input  logic [bvi_pkg::WordW-1:0]   image_length_i,
  input  logic [bvi_pkg::WordW-1:0]   expected_crc_i,
  input  logic [bvi_pkg::ByteW-1:0]   data_byte_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [2:0]                  status_o,
  output logic [bvi_pkg::WordW-1:0]   image_crc_o
);

  bvi_pkg::cfg_t cfg;
  bvi_pkg::res_t res;
  bvi_pkg::res_t out_res;
  logic          res_valid;
  logic          accept;
  logic          buf_full;

  assign in_stall_o = buf_full;
  assign accept     = in_valid_i && !buf_full;

  bvi_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  bvi_engine u_engine (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .kind_i           (kind_i),
    .magic_i          (magic_i),
    .header_version_i (header_version_i),
    .vector_base_i    (vector_base_i),
    .image_length_i   (image_length_i),
    .expected_crc_i   (expected_crc_i),
    .data_byte_i      (data_byte_i),
    .cfg_i            (cfg),
    .res_valid_o      (res_valid),
    .res_o            (res)
  );

  bvi_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_res)
  );

  assign status_o    = out_res.status;
  assign image_crc_o = out_res.crc;

`ifndef ASSERT_OFF
  a_no_result_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> !res_valid)
    else $error("result produced while output buffer is full");

  a_full_implies_out_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("buffer entry held without a pending output");

  a_crc_only_ok_or_mismatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != bvi_pkg::StOk && status_o != bvi_pkg::StCrc)
      |-> image_crc_o == '0)
    else $error("nonzero CRC reported with a header or vector failure");

  a_result_reaches_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |=> out_valid_o)
    else $error("result lost between engine and output");
`endif

endmodule

// ===== src/bvi_cfg.sv =====
module bvi_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bvi_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bvi_pkg::WordW-1:0]     cfg_data_i,
  output bvi_pkg::cfg_t                 cfg_o
);

  bvi_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (bvi_pkg::cfg_idx_e'(cfg_idx_i))
        bvi_pkg::CfgMagic:     cfg_d.magic = cfg_data_i;
        bvi_pkg::CfgVersion:   cfg_d.version = cfg_data_i;
        bvi_pkg::CfgVectBase:  cfg_d.vect_base = cfg_data_i;
        bvi_pkg::CfgMaxSize:   cfg_d.max_size = cfg_data_i;
        bvi_pkg::CfgStackLow:  cfg_d.stack_low = cfg_data_i;
        bvi_pkg::CfgStackHigh: cfg_d.stack_high = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic      <= '0;
      cfg_q.version    <= '0;
      cfg_q.vect_base  <= '0;
      cfg_q.max_size   <= bvi_pkg::MaxSizeReset;
      cfg_q.stack_low  <= bvi_pkg::StackLowReset;
      cfg_q.stack_high <= bvi_pkg::StackHighReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/bvi_engine.sv =====
module bvi_engine (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic                        kind_i,
  input  logic [bvi_pkg::WordW-1:0]   magic_i,
  input  logic [bvi_pkg::WordW-1:0]   header_version_i,
  input  logic [bvi_pkg::WordW-1:0]   vector_base_i,
  input  logic [bvi_pkg::WordW-1:0]   image_length_i,
  input  logic [bvi_pkg::WordW-1:0]   expected_crc_i,
  input  logic [bvi_pkg::ByteW-1:0]   data_byte_i,
  input  bvi_pkg::cfg_t               cfg_i,
  output logic                        res_valid_o,
  output bvi_pkg::res_t               res_o
);

  logic                       armed_q, armed_d;
  logic [bvi_pkg::WordW-1:0]  left_q, left_d;
  logic [3:0]                 pos_q, pos_d;
  logic [bvi_pkg::WordW-1:0]  crc_q, crc_d;
  logic [bvi_pkg::WordW-1:0]  base_q, base_d;
  logic [bvi_pkg::WordW-1:0]  end_q, end_d;
  logic [bvi_pkg::WordW-1:0]  hcrc_q, hcrc_d;
  logic [2*bvi_pkg::WordW-1:0] words_q, words_d;

  logic [bvi_pkg::WordW-1:0]  crc_next;
  logic [bvi_pkg::WordW-1:0]  msp;
  logic [bvi_pkg::WordW-1:0]  rv;
  logic [bvi_pkg::WordW-1:0]  pc;
  logic [bvi_pkg::WordW-1:0]  actual;

  assign crc_next = bvi_pkg::crc_byte(crc_q, data_byte_i);

  always_comb begin
    armed_d = armed_q;
    left_d  = left_q;
    pos_d   = pos_q;
    crc_d   = crc_q;
    base_d  = base_q;
    end_d   = end_q;
    hcrc_d  = hcrc_q;
    words_d = words_q;
    res_valid_o = 1'b0;
    res_o.status = bvi_pkg::StOk;
    res_o.crc = '0;
    msp = '0;
    rv = '0;
    pc = '0;
    actual = ~crc_next;

    if (accept_i && !kind_i) begin
      armed_d = 1'b0;
      res_valid_o = 1'b1;
      if (magic_i != cfg_i.magic) begin
        res_o.status = bvi_pkg::StMagic;
      end else if (header_version_i != cfg_i.version) begin
        res_o.status = bvi_pkg::StVersion;
      end else if (vector_base_i != cfg_i.vect_base) begin
        res_o.status = bvi_pkg::StVector;
      end else if (image_length_i < bvi_pkg::MinImage || image_length_i > cfg_i.max_size) begin
        res_o.status = bvi_pkg::StSize;
      end else begin
        res_valid_o = 1'b0;
        armed_d = 1'b1;
        left_d  = image_length_i;
        pos_d   = '0;
        crc_d   = bvi_pkg::CrcOnes;
        base_d  = vector_base_i;
        end_d   = vector_base_i + image_length_i;
        hcrc_d  = expected_crc_i;
        words_d = '0;
      end
    end else if (accept_i && kind_i && armed_q) begin
      crc_d = crc_next;
      if (pos_q < bvi_pkg::CaptureBytes) begin
        words_d[pos_q[2:0]*bvi_pkg::ByteW +: bvi_pkg::ByteW] = data_byte_i;
        pos_d = pos_q + 4'd1;
      end
      left_d = left_q - bvi_pkg::WordW'(1);
      msp = words_d[bvi_pkg::WordW-1:0];
      rv  = words_d[2*bvi_pkg::WordW-1:bvi_pkg::WordW];
      pc  = {rv[bvi_pkg::WordW-1:1], 1'b0};
      if (left_q == bvi_pkg::WordW'(1)) begin
        armed_d = 1'b0;
        res_valid_o = 1'b1;
        if (msp < cfg_i.stack_low || msp > cfg_i.stack_high) begin
          res_o.status = bvi_pkg::StStack;
        end else if (!rv[0] || pc < base_q || pc >= end_q) begin
          res_o.status = bvi_pkg::StReset;
        end else if (actual != hcrc_q) begin
          res_o.status = bvi_pkg::StCrc;
          res_o.crc = actual;
        end else begin
          res_o.status = bvi_pkg::StOk;
          res_o.crc = actual;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      left_q  <= '0;
      pos_q   <= '0;
      crc_q   <= bvi_pkg::CrcOnes;
    end else begin
      armed_q <= armed_d;
      left_q  <= left_d;
      pos_q   <= pos_d;
      crc_q   <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q  <= base_d;
    end_q   <= end_d;
    hcrc_q  <= hcrc_d;
    words_q <= words_d;
  end

endmodule

// ===== src/bvi_outbuf.sv =====
module bvi_outbuf (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          res_valid_i,
  input  bvi_pkg::res_t res_i,
  output logic          full_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bvi_pkg::res_t out_o
);

  logic          out_valid_q, out_valid_d;
  logic          skid_valid_q, skid_valid_d;
  bvi_pkg::res_t out_q, out_d;
  bvi_pkg::res_t skid_q, skid_d;
  logic          out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d  = out_q;
    skid_d = skid_q;
    if (out_free) begin
      out_valid_d  = skid_valid_q || res_valid_i;
      out_d        = skid_valid_q ? skid_q : res_i;
      skid_valid_d = 1'b0;
    end else if (res_valid_i) begin
      skid_valid_d = 1'b1;
      skid_d       = res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule
